// ===== hdl/wma_pkg.sv =====
// Shared constants, types and state codes for the weighted moving average block.
package wma_pkg;

   localparam int DEPTH_DEFAULT         = 16;
   localparam int SAMPLE_BITS_DEFAULT   = 16;
   localparam int FRACTION_BITS_DEFAULT = 4;

   localparam int                     LENGTH_BITS  = 5;
   localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = 5'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic negative;
   } div_ctrl_type;

endpackage

// ===== hdl/wma_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module wma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/wma_divider.sv =====
// Bit-serial restoring divider for the sign and magnitude of the weighted sum.
module wma_divider #(
   parameter int DIVIDEND_BITS = 28,
   parameter int DIVISOR_BITS  = 8,
   parameter int QUOTIENT_BITS = 20
) (
   input  logic                            clock,
   input  logic                            reset,
   input  wma_pkg::div_ctrl_type           ctrl,
   input  logic [DIVIDEND_BITS-1:0]        dividend,
   input  logic [DIVISOR_BITS-1:0]         divisor,
   output logic                            done,
   output logic signed [QUOTIENT_BITS-1:0] quotient
);

   localparam int CB = $clog2(DIVIDEND_BITS);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CB-1:0]            count_ff, count_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]  dvsr_ff, dvsr_in;
   logic                     neg_ff, neg_in;

   logic [DIVISOR_BITS:0]    rem_shift;
   logic                     fits;
   logic [QUOTIENT_BITS-1:0] q_mag;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      fits      = rem_shift >= {1'b0, dvsr_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvsr_in   = dvsr_ff;
      neg_in    = neg_ff;
      if (ctrl.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
         dvsr_in  = divisor;
         neg_in   = ctrl.negative;
      end else if (busy_ff) begin
         rem_in   = fits ? DIVISOR_BITS'(rem_shift - {1'b0, dvsr_ff})
                         : DIVISOR_BITS'(rem_shift);
         quo_in   = {quo_ff[DIVIDEND_BITS-2:0], fits};
         count_in = count_ff + CB'(1);
         if (count_ff == CB'(DIVIDEND_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvsr_ff  <= dvsr_in;
      neg_ff   <= neg_in;
   end

   assign q_mag    = quo_ff[QUOTIENT_BITS-1:0];
   assign quotient = neg_ff ? -q_mag : q_mag;
   assign done     = done_ff;

endmodule

// ===== hdl/weighted_moving_average_top.sv =====
// Top level of the linearly weighted moving average with running sums and serial divide.
// A request is accepted only while the block is idle; it then passes through the update,
// divide and done states, and the done state waits while a held response is stalled.
// One request is in flight at a time; the next is taken once the response is loaded,
// at a pace set by the bit-serial divider (one quotient bit per cycle) and output stalls.
// Synchronous reset empties the window and sets the window length to 16.
module weighted_moving_average_top #(
   parameter int DEPTH         = wma_pkg::DEPTH_DEFAULT,
   parameter int SAMPLE_BITS   = wma_pkg::SAMPLE_BITS_DEFAULT,
   parameter int FRACTION_BITS = wma_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic signed [SAMPLE_BITS-1:0]               req_sample,
   input  logic                                        req_restart,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic signed [SAMPLE_BITS+FRACTION_BITS-1:0] rsp_average,
   output logic [$clog2(DEPTH+1)-1:0]                  rsp_fill_count,
   input  logic                                        csr_wr_en,
   input  logic [wma_pkg::LENGTH_BITS-1:0]             csr_wr_data
);

   localparam int AB = SAMPLE_BITS + FRACTION_BITS;
   localparam int FB = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam int PB = SAMPLE_BITS + $clog2(DEPTH) + 1;
   localparam int WB = SAMPLE_BITS + $clog2(DEPTH * (DEPTH + 1) / 2);
   localparam int DB = WB + FRACTION_BITS;
   localparam int VB = $clog2(DEPTH * (DEPTH + 1) / 2 + 1);
   localparam int CW = (FB > wma_pkg::LENGTH_BITS) ? FB : wma_pkg::LENGTH_BITS;
   localparam int PW = SAMPLE_BITS + FB + 1;
   localparam int NB = 2 * FB + 1;

   wma_pkg::state_type state_ff, state_in;

   logic [wma_pkg::LENGTH_BITS-1:0] window_ff, window_in;
   logic [AW-1:0]                   pos_ff, pos_in;
   logic [FB-1:0]                   fill_ff, fill_in;
   logic signed [WB-1:0]            wsum_ff, wsum_in;
   logic signed [PB-1:0]            psum_ff, psum_in;
   logic signed [SAMPLE_BITS-1:0]   sample_ff, sample_in;
   logic                            restart_ff, restart_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [AB-1:0]            rsp_average_ff, rsp_average_in;
   logic [FB-1:0]                   rsp_fill_ff, rsp_fill_in;

   logic                 accept;
   logic                 load_rsp;
   logic [CW-1:0]        len_wide;
   logic [FB-1:0]        len;
   logic [AW-1:0]        pos_base;
   logic [FB-1:0]        fill_base;
   logic signed [WB-1:0] wsum_base;
   logic signed [PB-1:0] psum_base;
   logic                 full;
   logic [FB-1:0]        fill_upd;
   logic [FB-1:0]        mult_operand;
   logic signed [PW-1:0] prod;
   logic signed [WB-1:0] wsum_upd;
   logic signed [PB-1:0] psum_upd;
   logic [FB-1:0]        pos_inc;
   logic [AW-1:0]        pos_upd;
   logic [NB-1:0]        tri_prod;
   logic [VB-1:0]        divisor;
   logic [WB-1:0]        wsum_mag;
   logic [DB-1:0]        dividend;
   logic [SAMPLE_BITS-1:0] ring_rd_data;
   logic                 ring_wr_en;

   wma_pkg::div_ctrl_type div_ctrl;
   logic                  div_done;
   logic signed [AB-1:0]  div_quotient;

   assign accept = req_valid && !req_stall;

   always_comb begin
      len_wide = CW'(window_ff);
      if (window_ff == '0) begin
         len = FB'(1);
      end else if (len_wide > CW'(DEPTH)) begin
         len = FB'(DEPTH);
      end else begin
         len = FB'(len_wide);
      end
   end

   always_comb begin
      pos_base     = restart_ff ? '0 : pos_ff;
      fill_base    = restart_ff ? '0 : fill_ff;
      wsum_base    = restart_ff ? '0 : wsum_ff;
      psum_base    = restart_ff ? '0 : psum_ff;
      full         = fill_base >= len;
      fill_upd     = full ? fill_base : fill_base + FB'(1);
      mult_operand = full ? len : fill_upd;
      prod         = $signed({1'b0, mult_operand}) * sample_ff;
      if (full) begin
         wsum_upd = wsum_base - WB'(psum_base) + WB'(prod);
         psum_upd = psum_base - PB'($signed(ring_rd_data)) + PB'(sample_ff);
      end else begin
         wsum_upd = wsum_base + WB'(prod);
         psum_upd = psum_base + PB'(sample_ff);
      end
      pos_inc  = FB'(pos_base) + FB'(1);
      pos_upd  = (pos_inc >= len) ? '0 : AW'(pos_inc);
      tri_prod = NB'(fill_upd) * (NB'(fill_upd) + NB'(1));
      divisor  = VB'(tri_prod >> 1);
      wsum_mag = wsum_upd[WB-1] ? -wsum_upd : wsum_upd;
      dividend = DB'(wsum_mag) << FRACTION_BITS;
   end

   always_comb begin
      state_in          = state_ff;
      req_stall         = 1'b1;
      ring_wr_en        = 1'b0;
      load_rsp          = 1'b0;
      div_ctrl.start    = 1'b0;
      div_ctrl.negative = wsum_upd[WB-1];
      unique case (state_ff)
         wma_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = wma_pkg::ST_UPDATE;
            end
         end
         wma_pkg::ST_UPDATE: begin
            ring_wr_en     = 1'b1;
            div_ctrl.start = 1'b1;
            state_in       = wma_pkg::ST_DIVIDE;
         end
         wma_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = wma_pkg::ST_DONE;
            end
         end
         wma_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = wma_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wma_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      window_in      = window_ff;
      pos_in         = pos_ff;
      fill_in        = fill_ff;
      wsum_in        = wsum_ff;
      psum_in        = psum_ff;
      sample_in      = accept ? req_sample : sample_ff;
      restart_in     = accept ? req_restart : restart_ff;
      rsp_average_in = load_rsp ? div_quotient : rsp_average_ff;
      rsp_fill_in    = load_rsp ? fill_ff : rsp_fill_ff;
      rsp_valid_in   = load_rsp ? 1'b1 : (rsp_valid_ff && rsp_stall);
      if (csr_wr_en) begin
         window_in = csr_wr_data;
         pos_in    = '0;
         fill_in   = '0;
         wsum_in   = '0;
         psum_in   = '0;
      end else if (state_ff == wma_pkg::ST_UPDATE) begin
         pos_in  = pos_upd;
         fill_in = fill_upd;
         wsum_in = wsum_upd;
         psum_in = psum_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wma_pkg::ST_IDLE;
         window_ff    <= wma_pkg::LENGTH_RESET;
         pos_ff       <= '0;
         fill_ff      <= '0;
         wsum_ff      <= '0;
         psum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         wsum_ff      <= wsum_in;
         psum_ff      <= psum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff      <= sample_in;
      restart_ff     <= restart_in;
      rsp_average_ff <= rsp_average_in;
      rsp_fill_ff    <= rsp_fill_in;
   end

   wma_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (pos_base),
      .wr_data (sample_ff),
      .rd_en   (accept),
      .rd_addr (req_restart ? '0 : pos_ff),
      .rd_data (ring_rd_data)
   );

   wma_divider #(
      .DIVIDEND_BITS (DB),
      .DIVISOR_BITS  (VB),
      .QUOTIENT_BITS (AB)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_average    = rsp_average_ff;
   assign rsp_fill_count = rsp_fill_ff;

endmodule
